>>> rtl/bfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Shared types and fixed field widths for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

  // Widths of the result fields, fixed by the interface.
  localparam int CHOSEN_W = 4;
  localparam int SPACE_W  = 16;

  // Widths of the input fields, fixed by the interface.
  localparam int BLOCK_W  = 4;
  localparam int AMOUNT_W = 16;

  // Item kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage : bfba_pkg
`default_nettype wire

>>> rtl/bfba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module bfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : bfba_ram
`default_nettype wire

>>> rtl/best_fit_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Keeps the free size of each block in a RAM. A request scans every entry
// for the smallest block that still fits, then writes its reduced size back if one fits.
// ----------------------------------------------------------------------------
// A load writes the RAM in the cycle it is accepted, and busy stays low throughout.
// A request holds busy through ST_SCAN, ST_LAST and ST_DONE: one RAM read per
// block in ST_SCAN, the last compare in ST_LAST and write-back in ST_DONE;
// out_valid rises in the same cycle that busy falls. The receiver cannot stall.
// Synchronous active-low reset clears all block sizes to zero at once
// through per-block valid bits; no clearing pass is needed.
module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_kind,
  input  wire logic [BLOCK_W-1:0]  in_block_number,
  input  wire logic [AMOUNT_W-1:0] in_amount,
  output logic                     out_valid,
  output logic                     out_allocated,
  output logic [CHOSEN_W-1:0]      out_chosen_block,
  output logic [SPACE_W-1:0]       out_space_left
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  // Sequencer and scan state.
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [SIZE_BITS-1:0]   amt_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [SIZE_BITS-1:0]   best_size_r;
  logic [NUM_BLOCKS-1:0]  valid_r;

  // Result registers.
  logic                   out_valid_r;
  logic                   out_allocated_r;
  logic [CHOSEN_W-1:0]    out_chosen_block_r;
  logic [SPACE_W-1:0]     out_space_left_r;

  // Input decoding and width adaption.
  logic                   accept;
  logic [31:0]            blk_ext;
  logic [31:0]            amt_ext;
  logic [SIZE_BITS-1:0]   amt_in;
  logic                   load_ok;
  logic [IDX_W-1:0]       load_addr;

  // RAM ports.
  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  logic [SIZE_BITS-1:0]   ram_wr_data;
  logic                   ram_rd_en;
  logic [SIZE_BITS-1:0]   ram_rd_data;

  // Compare and write-back values.
  logic [SIZE_BITS-1:0]   cur_size;
  logic                   fits;
  logic [SIZE_BITS-1:0]   new_size;
  logic [31:0]            idx_ext;
  logic [31:0]            size_ext;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign blk_ext   = 32'(in_block_number);
  assign amt_ext   = 32'(in_amount);
  assign amt_in    = amt_ext[SIZE_BITS-1:0];
  assign load_ok   = (blk_ext < 32'(NUM_BLOCKS));
  assign load_addr = blk_ext[IDX_W-1:0];

  // A block that was never written since reset reads as size zero.
  assign cur_size = valid_r[cmp_idx_r] ? ram_rd_data : '0;
  assign fits     = (cur_size >= amt_r) && (!found_r || (cur_size < best_size_r));
  assign new_size = best_size_r - amt_r;
  assign idx_ext  = 32'(best_idx_r);
  assign size_ext = 32'(new_size);

  // RAM accesses: loads write in idle, requests write back at the end.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = load_addr;
    ram_wr_data = amt_in;
    if (accept && (in_kind == KIND_LOAD) && load_ok) begin
      ram_wr_en = 1'b1;
    end else if ((state_r == ST_DONE) && found_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = best_idx_r;
      ram_wr_data = new_size;
    end
  end

  assign ram_rd_en = (state_r == ST_SCAN);

  bfba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_cnt_r),
    .rd_data (ram_rd_data)
  );

  // Next-state logic for the scan sequencer.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (accept && (in_kind == KIND_REQUEST)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cmp_vld_r   <= ram_rd_en;
      out_valid_r <= (state_r == ST_DONE);
      if (accept) begin
        found_r <= 1'b0;
      end else if (cmp_vld_r && fits) begin
        found_r <= 1'b1;
      end
      if (ram_wr_en) begin
        valid_r[ram_wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers: request amount, best candidate and the result.
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_cnt_r;
    if (accept) begin
      amt_r <= amt_in;
    end
    if (cmp_vld_r && fits) begin
      best_idx_r  <= cmp_idx_r;
      best_size_r <= cur_size;
    end
    if (state_r == ST_DONE) begin
      out_allocated_r    <= found_r;
      out_chosen_block_r <= found_r ? idx_ext[CHOSEN_W-1:0] : '0;
      out_space_left_r   <= found_r ? size_ext[SPACE_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_allocated    = out_allocated_r;
  assign out_chosen_block = out_chosen_block_r;
  assign out_space_left   = out_space_left_r;

endmodule : best_fit_block_allocator
`default_nettype wire

>>> tb/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives loads and allocation requests through the start/busy command port.
// A scoreboard keeps its own copy of the free size of every block, works out
// the placement of each accepted request and checks every strobed result in
// order.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_tb;
  import bfba_pkg::*;

  localparam int NUM_BLOCKS  = 16;
  localparam int SIZE_BITS   = 16;
  localparam int RAND_ITEMS  = 2000;
  localparam int TAIL_CYCLES = NUM_BLOCKS + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  // One expected placement outcome.
  typedef struct packed {
    logic                allocated;
    logic [CHOSEN_W-1:0] chosen_block;
    logic [SPACE_W-1:0]  space_left;
  } placement_t;

  // Scoreboard: tracks block sizes and the placements still to arrive.
  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] free_size [NUM_BLOCKS];
    placement_t           pending_placements [$];
    int unsigned          mismatches;
    int unsigned          unexpected;
    int unsigned          results_seen;
    int unsigned          loads_seen;
    int unsigned          requests_seen;
    int unsigned          fits_seen;
    int unsigned          misses_seen;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      mismatches    = 0;
      unexpected    = 0;
      results_seen  = 0;
      loads_seen    = 0;
      requests_seen = 0;
      fits_seen     = 0;
      misses_seen   = 0;
    endfunction

    // Applies one accepted transfer and queues the placement it causes.
    function void note_transfer(logic kind, logic [BLOCK_W-1:0] blk,
                                logic [AMOUNT_W-1:0] amount);
      logic [SIZE_BITS-1:0] amt;
      logic [SIZE_BITS-1:0] best_size;
      placement_t           res;
      bit                   found;
      int                   best;
      amt       = SIZE_BITS'(amount);
      found     = 1'b0;
      best      = 0;
      best_size = '0;
      if (kind == KIND_LOAD) begin
        if (int'(blk) < NUM_BLOCKS) free_size[blk] = amt;
        loads_seen++;
        return;
      end
      requests_seen++;
      // Smallest block that still fits; the lowest index wins a tie.
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (free_size[i] >= amt && (!found || free_size[i] < best_size)) begin
          found     = 1'b1;
          best      = i;
          best_size = free_size[i];
        end
      end
      if (!found) begin
        res = '0;
        misses_seen++;
      end else begin
        free_size[best]  = best_size - amt;
        res.allocated    = 1'b1;
        res.chosen_block = CHOSEN_W'(best);
        res.space_left   = SPACE_W'(free_size[best]);
        fits_seen++;
      end
      pending_placements.push_back(res);
    endfunction

    // Compares one strobed result with the oldest pending placement.
    function void check_result(logic alloc, logic [CHOSEN_W-1:0] chosen,
                               logic [SPACE_W-1:0] space);
      placement_t exp_res;
      results_seen++;
      if (pending_placements.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_MAX)
          $display("Unexpected result: allocated=%0b block=%0d space=%0d",
                   alloc, chosen, space);
        return;
      end
      exp_res = pending_placements.pop_front();
      if (alloc !== exp_res.allocated || chosen !== exp_res.chosen_block ||
          space !== exp_res.space_left) begin
        mismatches++;
        if (mismatches + unexpected <= REPORT_MAX)
          $display("Mismatch on result %0d: expected allocated=%0b block=%0d space=%0d, %s",
                   results_seen, exp_res.allocated, exp_res.chosen_block,
                   exp_res.space_left,
                   $sformatf("got allocated=%0b block=%0d space=%0d", alloc, chosen, space));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_kind;
  logic [BLOCK_W-1:0]  in_block_number;
  logic [AMOUNT_W-1:0] in_amount;
  logic                out_valid;
  logic                out_allocated;
  logic [CHOSEN_W-1:0] out_chosen_block;
  logic [SPACE_W-1:0]  out_space_left;

  alloc_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     strobe_errors = 0;

  best_fit_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_block_number (in_block_number),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_allocated   (out_allocated),
    .out_chosen_block(out_chosen_block),
    .out_space_left  (out_space_left)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: results are checked before the transfer of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        sb.check_result(out_allocated, out_chosen_block, out_space_left);
      end else if (out_valid !== 1'b0) begin
        strobe_errors++;
        if (strobe_errors <= REPORT_MAX) $display("Result strobe is unknown");
      end
      if (start && !busy) sb.note_transfer(in_kind, in_block_number, in_amount);
    end
  end

  // Presents one item after an idle gap and holds it until the transfer.
  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic kind, input logic [BLOCK_W-1:0] blk,
                           input logic [AMOUNT_W-1:0] amt, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind         = kind;
    in_block_number = blk;
    in_amount       = amt;
    start           = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    bit                   no_idle;
    int                   gap;
    int                   r;
    int                   m;
    int                   d;
    logic [BLOCK_W-1:0]   blk;
    logic [AMOUNT_W-1:0]  amt;
    logic [SIZE_BITS-1:0] s;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_LOAD;
    in_block_number = '0;
    in_amount       = '0;
    no_idle         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty store, zero requests, ties, exact fits and misses.
    send_item(KIND_REQUEST, 4'd9,  16'h0000, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd0,  16'h0001, $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd15, 16'hFFFF, $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd3,  16'd100,  $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd7,  16'd100,  $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd0,  16'd50,   $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd15, 16'd60,   $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd5,  16'd40,   $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd0,  16'hFFFF, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd0,  16'hFFFF, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd12, 16'h0000, $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd0,  16'hFFFF, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd6,  16'hFFFF, $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd10, 16'h8000, $urandom_range(0, 4));
    send_item(KIND_LOAD,    4'd5,  16'h7FFF, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd10, 16'h7FFF, $urandom_range(0, 4));
    send_item(KIND_REQUEST, 4'd1,  16'h0001, 0);
    send_item(KIND_REQUEST, 4'd2,  16'h8001, 0);

    // Random part: loads keep the store populated so most requests find a fit.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 4);
      blk = BLOCK_W'($urandom_range(0, 15));
      r   = $urandom_range(0, 99);
      m   = $urandom_range(0, 3);
      if (r < 35) begin
        case (m)
          0: amt = AMOUNT_W'($urandom_range(0, 16'hFFFF));
          1: amt = AMOUNT_W'($urandom_range(0, 255));
          2: amt = AMOUNT_W'(sb.free_size[$urandom_range(0, NUM_BLOCKS - 1)]);
          default: amt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        send_item(KIND_LOAD, blk, amt, gap);
      end else begin
        s = sb.free_size[$urandom_range(0, NUM_BLOCKS - 1)];
        d = $urandom_range(0, 15);
        case (m)
          0: amt = AMOUNT_W'(s);
          1: amt = (int'(s) > d) ? AMOUNT_W'(int'(s) - d) : '0;
          2: amt = AMOUNT_W'($urandom_range(0, 127));
          default: amt = AMOUNT_W'($urandom_range(0, 16'hFFFF));
        endcase
        send_item(KIND_REQUEST, blk, amt, gap);
      end
    end
    start = 1'b0;

    // Drain the outstanding placements, then allow for a final scan.
    while (sb.pending_placements.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d loads and %0d requests, %0d results checked.",
             sb.loads_seen, sb.requests_seen, sb.results_seen);
    $display("Requests placed: %0d, with no fitting block: %0d, failures: %0d.",
             sb.fits_seen, sb.misses_seen,
             sb.mismatches + sb.unexpected + strobe_errors + sb.pending_placements.size());
    if (sb.mismatches == 0 && sb.unexpected == 0 && strobe_errors == 0 &&
        sb.pending_placements.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : best_fit_block_allocator_tb
